### design/ncrc_pkg.sv
package ncrc_pkg;

  localparam logic [15:0] SeedA = 16'h6363;
  localparam logic [15:0] SeedB = 16'hFFFF;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  typedef enum logic [1:0] {
    KIND_ECHO,
    KIND_ECHO_CRC,
    KIND_VERDICT
  } kind_e;

  typedef enum logic [1:0] {
    PH_DATA,
    PH_CRC_LO,
    PH_CRC_HI
  } phase_e;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_CHECK  = 1'b1
  } opcode_e;

  typedef enum logic {
    MODE_CRC_A = 1'b0,
    MODE_CRC_B = 1'b1
  } mode_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [15:0] crc;
    logic        ok;
  } entry_t;

  // reflected 0x8408 update, one byte
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] byte_in);
    logic [7:0] b;
    b = byte_in ^ crc[7:0];
    b = b ^ {b[3:0], 4'b0000};
    return {8'h00, crc[15:8]} ^ {b, 8'h00} ^ {5'b00000, b, 3'b000}
           ^ {12'h000, b[7:4]};
  endfunction

endpackage

### design/ncrc_front.sv
module ncrc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  input  logic [0:0]      cfg_data_i,
  input  logic            in_valid_i,
  input  logic            space_i,
  input  logic            opcode_i,
  input  logic [7:0]      data_byte_i,
  input  logic            frame_end_i,
  output logic            in_ready_o,
  output logic            push_o,
  output ncrc_pkg::entry_t push_entry_o
);
  import ncrc_pkg::*;

  logic        crc_mode_q;
  logic [15:0] crc_q, crc_d;
  logic        in_frame_q;
  logic [15:0] tail_q, tail_d;
  logic [1:0]  seen_q, seen_d;

  logic        accept;
  logic        check;
  logic [15:0] crc_base, tail_base, final_crc;
  logic [1:0]  seen_base;

  assign in_ready_o = space_i;
  assign accept     = in_valid_i && space_i;
  assign check      = (opcode_i == OP_CHECK);

  always_comb begin
    if (!in_frame_q) begin
      crc_base  = (crc_mode_q == MODE_CRC_B) ? SeedB : SeedA;
      tail_base = 16'h0000;
      seen_base = 2'd0;
    end else begin
      crc_base  = crc_q;
      tail_base = tail_q;
      seen_base = seen_q;
    end
    // check bytes enter the crc only when they leave the two-byte delay line
    if (check) begin
      crc_d = (seen_base == 2'd2) ? crc_byte(crc_base, tail_base[7:0]) : crc_base;
    end else begin
      crc_d = crc_byte(crc_base, data_byte_i);
    end
    tail_d    = {data_byte_i, tail_base[15:8]};
    seen_d    = (seen_base == 2'd2) ? 2'd2 : seen_base + 2'd1;
    final_crc = (crc_mode_q == MODE_CRC_B) ? ~crc_d : crc_d;
  end

  always_comb begin
    push_o            = accept && (!check || frame_end_i);
    push_entry_o.data = data_byte_i;
    push_entry_o.crc  = final_crc;
    push_entry_o.ok   = (seen_d == 2'd2) && (tail_d == final_crc);
    if (check) begin
      push_entry_o.kind = KIND_VERDICT;
    end else if (frame_end_i) begin
      push_entry_o.kind = KIND_ECHO_CRC;
    end else begin
      push_entry_o.kind = KIND_ECHO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_mode_q <= MODE_CRC_A;
      crc_q      <= SeedA;
      in_frame_q <= 1'b0;
      tail_q     <= 16'h0000;
      seen_q     <= 2'd0;
    end else begin
      if (cfg_valid_i) begin
        crc_mode_q <= cfg_data_i[0];
      end
      if (accept) begin
        crc_q      <= crc_d;
        tail_q     <= tail_d;
        seen_q     <= seen_d;
        in_frame_q <= !frame_end_i;
      end
    end
  end

endmodule

### design/ncrc_queue.sv
module ncrc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ncrc_pkg::entry_t push_entry_i,
  output logic             space_o,
  input  logic             pop_i,
  output logic             head_valid_o,
  output ncrc_pkg::entry_t head_o
);
  import ncrc_pkg::*;

  entry_t              mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]   count_q;

  logic do_push, do_pop;

  assign space_o      = (count_q != (QueuePtrW + 1)'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && space_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (QueuePtrW + 1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (QueuePtrW + 1)'(1);
      end
    end
  end

endmodule

### design/ncrc_back.sv
module ncrc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  ncrc_pkg::entry_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             is_check_result_o,
  output logic             crc_ok_o,
  output logic             out_last_o
);
  import ncrc_pkg::*;

  phase_e     phase_q, phase_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q, byte_d;
  logic       chk_q, chk_d;
  logic       ok_q, ok_d;
  logic       last_q, last_d;

  logic load, emit, done;

  assign load = !out_valid_q || out_ready_i;
  assign emit = head_valid_i && load;

  // beat contents for the current entry and phase
  always_comb begin
    byte_d = head_i.data;
    chk_d  = 1'b0;
    ok_d   = 1'b0;
    last_d = 1'b0;
    done   = 1'b1;
    case (head_i.kind)
      KIND_VERDICT: begin
        byte_d = 8'h00;
        chk_d  = 1'b1;
        ok_d   = head_i.ok;
        last_d = 1'b1;
      end
      KIND_ECHO_CRC: begin
        case (phase_q)
          PH_DATA: begin
            done = 1'b0;
          end
          PH_CRC_LO: begin
            byte_d = head_i.crc[7:0];
            done   = 1'b0;
          end
          PH_CRC_HI: begin
            byte_d = head_i.crc[15:8];
            last_d = 1'b1;
          end
          default: begin
            done = 1'b0;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    if (emit) begin
      if (done) begin
        phase_d = PH_DATA;
      end else begin
        case (phase_q)
          PH_DATA:   phase_d = PH_CRC_LO;
          PH_CRC_LO: phase_d = PH_CRC_HI;
          default:   phase_d = PH_DATA;
        endcase
      end
    end
  end

  assign pop_o       = emit && done;
  assign out_valid_d = load ? emit : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_DATA;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q <= byte_d;
      chk_q  <= chk_d;
      ok_q   <= ok_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_byte_o        = byte_q;
  assign is_check_result_o = chk_q;
  assign crc_ok_o          = ok_q;
  assign out_last_o        = last_q;

endmodule

### design/nfc_crc16_append_check_core.sv
// CRC-16 append/check engine for ISO 14443 frames (CRC_A / CRC_B).
// Input channel: one frame byte per beat (opcode_i, data_byte_i,
// frame_end_i). Append frames echo every byte and add the CRC low then
// high byte after the last one; check frames give one verdict beat at
// the end, comparing the last two bytes against the CRC of the rest.
// Output channel: out_byte_o, is_check_result_o, crc_ok_o, out_last_o.
// Config channel: cfg_data_i[0] picks seed 0x6363 (0) or 0xFFFF with
// inverted result (1); always ready, write it between frames.
// A result passes through the queue and then the output register before
// it reaches the output. Throughput: one byte per cycle in while the
// queue has space; the output runs at one beat per cycle while
// out_ready_i is high, so the end of an append frame costs three beats.
// A four-entry queue between the CRC front end and the output sequencer
// absorbs those bursts; in_ready_o drops only when the queue is full.
// When the receiver stalls the output register holds its beat, the queue
// fills and input is then back-pressured. Reset clears the queue, the
// output register, the open-frame state and selects CRC_A.
module nfc_crc16_append_check_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [0:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       opcode_i,
  input  logic [7:0] data_byte_i,
  input  logic       frame_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       is_check_result_o,
  output logic       crc_ok_o,
  output logic       out_last_o
);
  import ncrc_pkg::*;

  logic   space, push, pop, head_valid;
  entry_t push_entry, head;

  assign cfg_ready_o = 1'b1;

  ncrc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .space_i      (space),
    .opcode_i     (opcode_i),
    .data_byte_i  (data_byte_i),
    .frame_end_i  (frame_end_i),
    .in_ready_o   (in_ready_o),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  ncrc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .space_o      (space),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  ncrc_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_valid_i      (head_valid),
    .head_i            (head),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_byte_o        (out_byte_o),
    .is_check_result_o (is_check_result_o),
    .crc_ok_o          (crc_ok_o),
    .out_last_o        (out_last_o)
  );

endmodule
